### sv/fppid_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point PID step package
// Shared types and constants: configuration register indexes, the
// configuration record and the reset values of the drive limits.
// ----------------------------------------------------------------------------
`default_nettype none

package fppid_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned GainBits   = 16;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned ErrBits    = SampleBits + 1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_DRIVE_FLOOR   = 3'd3,
    REG_DRIVE_CEILING = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [GainBits-1:0]   gain_prop;
    logic        [GainBits-1:0]   gain_integ;
    logic        [GainBits-1:0]   gain_deriv;
    logic signed [SampleBits-1:0] drive_floor;
    logic signed [SampleBits-1:0] drive_ceiling;
  } cfg_t;

  localparam logic [SampleBits-1:0] DriveFloorReset   = 16'h8000;
  localparam logic [SampleBits-1:0] DriveCeilingReset = 16'h7FFF;

endpackage

`default_nettype wire

### sv/fppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// Fixed-point PID configuration registers
// Holds the three gains and the two drive limits, written over a simple
// valid/ready channel. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fppid_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fppid_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [fppid_pkg::GainBits-1:0]   cfg_data_i,
  output fppid_pkg::cfg_t                       cfg_o
);

  fppid_pkg::cfg_t cfg_q, cfg_d;

  // Registers can always take a write.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (fppid_pkg::cfg_reg_e'(cfg_index_i))
        fppid_pkg::REG_GAIN_PROP:     cfg_d.gain_prop     = cfg_data_i;
        fppid_pkg::REG_GAIN_INTEG:    cfg_d.gain_integ    = cfg_data_i;
        fppid_pkg::REG_GAIN_DERIV:    cfg_d.gain_deriv    = cfg_data_i;
        fppid_pkg::REG_DRIVE_FLOOR:   cfg_d.drive_floor   = $signed(cfg_data_i);
        fppid_pkg::REG_DRIVE_CEILING: cfg_d.drive_ceiling = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop     <= '0;
      cfg_q.gain_integ    <= '0;
      cfg_q.gain_deriv    <= '0;
      cfg_q.drive_floor   <= $signed(fppid_pkg::DriveFloorReset);
      cfg_q.drive_ceiling <= $signed(fppid_pkg::DriveCeilingReset);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/fppid_core.sv
// ----------------------------------------------------------------------------
// Fixed-point PID arithmetic core
// Combinational step: error, three gain products, saturating integrator,
// clamped derivative, limit clamp and round-half-up to the drive value.
// ----------------------------------------------------------------------------
`default_nettype none

module fppid_core #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned ACC_BITS      = 32
) (
  input  wire fppid_pkg::cfg_t                           cfg_i,
  input  wire logic signed [fppid_pkg::SampleBits-1:0]   setpoint_i,
  input  wire logic signed [fppid_pkg::SampleBits-1:0]   feedback_i,
  input  wire logic signed [ACC_BITS-1:0]                acc_i,
  input  wire logic signed [fppid_pkg::SampleBits-1:0]   prev_setpoint_i,
  input  wire logic signed [fppid_pkg::ErrBits-1:0]      prev_error_i,
  output logic signed [ACC_BITS-1:0]                     acc_o,
  output logic signed [fppid_pkg::SampleBits-1:0]        prev_setpoint_o,
  output logic signed [fppid_pkg::ErrBits-1:0]           prev_error_o,
  output logic        [fppid_pkg::SampleBits-1:0]        drive_o
);

  localparam int unsigned SW  = fppid_pkg::SampleBits;
  localparam int unsigned EW  = fppid_pkg::ErrBits;
  localparam int unsigned PW  = EW + fppid_pkg::GainBits + 1;  // gain x error
  localparam int unsigned IW  = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;
  localparam int unsigned SUW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 2;
  localparam int unsigned DW  = EW + 2;

  localparam logic signed [IW-1:0] AccMax =
    {{(IW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [IW-1:0] AccMin =
    {{(IW-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [DW-1:0] DvMax = DW'(32767);
  localparam logic signed [DW-1:0] DvMin = -DW'(32768);

  logic signed [EW-1:0]  err;
  logic signed [PW-1:0]  p_prod, i_prod;
  logic signed [IW-1:0]  acc_sum, acc_sat;
  logic signed [ACC_BITS-1:0] i_term;
  logic signed [DW-1:0]  dv;
  logic signed [SW-1:0]  dv_clamp;
  logic signed [PW-2:0]  d_prod;
  logic                  integ_on, deriv_on;
  logic signed [SUW-1:0] sum, hi, lo, clamped, q;
  logic                  half;

  assign integ_on = (cfg_i.gain_integ != '0);
  assign deriv_on = (cfg_i.gain_deriv != '0);

  always_comb begin
    err    = EW'(setpoint_i) - EW'(feedback_i);
    p_prod = $signed({1'b0, cfg_i.gain_prop}) * PW'(err);
    i_prod = $signed({1'b0, cfg_i.gain_integ}) * PW'(err);

    // Integrator with saturation to the signed accumulator range.
    acc_sum = IW'(acc_i) + IW'(i_prod);
    if (acc_sum > AccMax) begin
      acc_sat = AccMax;
    end else if (acc_sum < AccMin) begin
      acc_sat = AccMin;
    end else begin
      acc_sat = acc_sum;
    end
    acc_o  = integ_on ? acc_sat[ACC_BITS-1:0] : acc_i;
    i_term = integ_on ? acc_sat[ACC_BITS-1:0] : '0;

    // Derivative on error minus setpoint change, clamped to 16 bits.
    dv = (DW'(err) - DW'(prev_error_i)) - (DW'(setpoint_i) - DW'(prev_setpoint_i));
    if (dv > DvMax) begin
      dv_clamp = SW'(DvMax);
    end else if (dv < DvMin) begin
      dv_clamp = SW'(DvMin);
    end else begin
      dv_clamp = dv[SW-1:0];
    end
    d_prod          = deriv_on ? ($signed({1'b0, cfg_i.gain_deriv}) * (PW-1)'(dv_clamp)) : '0;
    prev_setpoint_o = deriv_on ? setpoint_i : prev_setpoint_i;
    prev_error_o    = deriv_on ? err : prev_error_i;

    // Sum, clamp to the scaled limits (ceiling checked first), then round.
    sum = SUW'(p_prod) + SUW'(i_term) + SUW'(d_prod);
    hi  = SUW'(cfg_i.drive_ceiling) <<< FRACTION_BITS;
    lo  = SUW'(cfg_i.drive_floor) <<< FRACTION_BITS;
    if (sum > hi) begin
      clamped = hi;
    end else if (sum < lo) begin
      clamped = lo;
    end else begin
      clamped = sum;
    end
    q       = clamped >>> FRACTION_BITS;
    half    = clamped[FRACTION_BITS-1];
    drive_o = q[SW-1:0] + {{(SW-1){1'b0}}, half};
  end

endmodule

`default_nettype wire

### sv/fixed_point_pid_step.sv
// ----------------------------------------------------------------------------
// Fixed-point PID step, top level
// One sample pair in, one rounded and saturated drive value out per beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                       Payload
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o setpoint, feedback
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i drive
//  cfg       in         cfg_valid_i/cfg_ready_o         index, 16-bit data
//
//  A new beat is taken every cycle while the result side is not stalled;
//  its result passes the input register, then the result register, before
//  it is offered.
//  The throughput is set by the single registered pass through the core:
//  the integrator and derivative history update at the edge that loads the
//  result, so the next beat in the input register sees the fresh state.
//  Reset clears the integrator, the derivative history, the gains and puts
//  the drive limits at the full 16-bit range.
//  A stalled result holds the result register; once the input register is
//  occupied as well it holds too and s_axis_tready_o drops until the result
//  leaves.
//
`default_nettype none

module fixed_point_pid_step #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned ACC_BITS      = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input stream. tdata: [15:0] setpoint, [31:16] feedback.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [31:0]                      s_axis_tdata_i,
  // Output stream. tdata: [15:0] drive.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [15:0]                           m_axis_tdata_o,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fppid_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [fppid_pkg::GainBits-1:0]   cfg_data_i
);

  localparam int unsigned SW = fppid_pkg::SampleBits;
  localparam int unsigned EW = fppid_pkg::ErrBits;

  fppid_pkg::cfg_t cfg;

  // Input register.
  logic                 in_valid_q, in_valid_d;
  logic signed [SW-1:0] in_setpoint_q, in_feedback_q;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic        [SW-1:0] drive_q;

  // Controller state.
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [SW-1:0]       prev_setpoint_q, prev_setpoint_d;
  logic signed [EW-1:0]       prev_error_q, prev_error_d;
  logic        [SW-1:0]       drive_d;

  logic out_free, in_advance, in_take;

  fppid_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fppid_core #(
    .FRACTION_BITS (FRACTION_BITS),
    .ACC_BITS      (ACC_BITS)
  ) u_core (
    .cfg_i           (cfg),
    .setpoint_i      (in_setpoint_q),
    .feedback_i      (in_feedback_q),
    .acc_i           (acc_q),
    .prev_setpoint_i (prev_setpoint_q),
    .prev_error_i    (prev_error_q),
    .acc_o           (acc_d),
    .prev_setpoint_o (prev_setpoint_d),
    .prev_error_o    (prev_error_d),
    .drive_o         (drive_d)
  );

  // The result register can load when empty or when its beat leaves now.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_advance      = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d  = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;
    out_valid_d = out_free ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      acc_q           <= '0;
      prev_setpoint_q <= '0;
      prev_error_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // State moves only when a beat passes through the core.
      if (in_advance) begin
        acc_q           <= acc_d;
        prev_setpoint_q <= prev_setpoint_d;
        prev_error_q    <= prev_error_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_setpoint_q <= $signed(s_axis_tdata_i[15:0]);
      in_feedback_q <= $signed(s_axis_tdata_i[31:16]);
    end
    if (in_advance) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = drive_q;

endmodule

`default_nettype wire

### sv/fppid_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point PID step port checker
// Watches the top-level ports for reset, stall and latency behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module fppid_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // No result is offered in the cycle after reset is seen low.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A stalled result keeps its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // Every accepted beat is followed by a valid result once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> ##2 m_axis_tvalid_o)
    else $error("result missing after accepted beat");

  // Input side is open whenever the output side is not stalled.
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input blocked without output stall");

endmodule

bind fixed_point_pid_step fppid_checker u_fppid_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

### test/fixed_point_pid_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point PID step testbench
// Streams setpoint/feedback beats through the controller and compares every
// drive beat with a cycle-free model of the PID arithmetic. Gains and drive
// limits are reprogrammed between phases while the block is drained. Both
// stream sides idle at random, and one long output hold-off back-pressures
// the input.
// ----------------------------------------------------------------------------
module fixed_point_pid_step_tb;

  localparam int unsigned FracBits = 8;
  localparam int unsigned AccBits  = 32;

  // Run shape. Directed beats come first, then the random phases.
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 115;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 4;
  localparam int StallLimit  = 2000;

  // Indexes above the last register are decoded as nothing at all.
  localparam logic [fppid_pkg::CfgIdxBits-1:0] FirstUnusedIdx =
    fppid_pkg::CfgIdxBits'(fppid_pkg::REG_DRIVE_CEILING + 1);

  // Model of the controller. It keeps its own copy of the registers and of
  // the integrator and derivative history, and queues one predicted drive
  // value per accepted sample beat.
  class pid_drive_board;
    fppid_pkg::cfg_t                  regs;
    longint                           integ_acc;
    longint                           last_setpoint;
    longint                           last_error;
    logic [fppid_pkg::SampleBits-1:0] drive_due[$];
    int                               failures;
    int                               samples_seen;
    int                               drives_seen;
    int                               writes_seen;

    function new();
      regs               = '0;
      regs.drive_floor   = fppid_pkg::DriveFloorReset;
      regs.drive_ceiling = fppid_pkg::DriveCeilingReset;
      integ_acc          = 0;
      last_setpoint      = 0;
      last_error         = 0;
      failures           = 0;
      samples_seen       = 0;
      drives_seen        = 0;
      writes_seen        = 0;
    endfunction

    function void write_reg(logic [fppid_pkg::CfgIdxBits-1:0] idx,
                            logic [fppid_pkg::GainBits-1:0] data);
      writes_seen++;
      case (idx)
        fppid_pkg::REG_GAIN_PROP:     regs.gain_prop     = data;
        fppid_pkg::REG_GAIN_INTEG:    regs.gain_integ    = data;
        fppid_pkg::REG_GAIN_DERIV:    regs.gain_deriv    = data;
        fppid_pkg::REG_DRIVE_FLOOR:   regs.drive_floor   = data;
        fppid_pkg::REG_DRIVE_CEILING: regs.drive_ceiling = data;
        default: ;
      endcase
    endfunction

    function logic [fppid_pkg::SampleBits-1:0] predict_drive(
        logic signed [fppid_pkg::SampleBits-1:0] sp,
        logic signed [fppid_pkg::SampleBits-1:0] fb);
      longint acc_max, acc_min, err, pterm, iterm, dterm, dv, sum, hi, lo, q;
      acc_max = (longint'(1) <<< (AccBits - 1)) - 1;
      acc_min = -acc_max - 1;
      err     = longint'(sp) - longint'(fb);
      pterm   = longint'(regs.gain_prop) * err;
      iterm   = 0;
      dterm   = 0;
      // A zero integral gain freezes the integrator and drops its term.
      if (regs.gain_integ != 0) begin
        integ_acc = integ_acc + err * longint'(regs.gain_integ);
        if (integ_acc > acc_max) integ_acc = acc_max;
        else if (integ_acc < acc_min) integ_acc = acc_min;
        iterm = integ_acc;
      end
      // The history only moves while the derivative gain is nonzero.
      if (regs.gain_deriv != 0) begin
        dv            = (err - last_error) - (longint'(sp) - last_setpoint);
        last_setpoint = sp;
        last_error    = err;
        if (dv > 32767) dv = 32767;
        else if (dv < -32768) dv = -32768;
        dterm = longint'(regs.gain_deriv) * dv;
      end
      sum = pterm + iterm + dterm;
      hi  = longint'(regs.drive_ceiling) * (longint'(1) <<< FracBits);
      lo  = longint'(regs.drive_floor) * (longint'(1) <<< FracBits);
      // The ceiling is checked first; with crossed limits a sum above it lands on it, any other on the floor.
      if (sum > hi) sum = hi;
      else if (sum < lo) sum = lo;
      q = sum >>> FracBits;
      return fppid_pkg::SampleBits'(q + longint'(sum[FracBits-1]));
    endfunction

    function void note_sample(logic signed [fppid_pkg::SampleBits-1:0] sp,
                              logic signed [fppid_pkg::SampleBits-1:0] fb);
      samples_seen++;
      drive_due.push_back(predict_drive(sp, fb));
    endfunction

    function void check_drive(logic [fppid_pkg::SampleBits-1:0] got);
      logic [fppid_pkg::SampleBits-1:0] want;
      drives_seen++;
      if (drive_due.size() == 0) begin
        failures++;
        $error("drive: beat with nothing expected, actual %0d", $signed(got));
      end else begin
        want = drive_due.pop_front();
        if (want !== got) begin
          failures++;
          $error("drive: expected %0d, actual %0d", $signed(want), $signed(got));
        end
      end
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  // Every block input has a known value from time zero.
  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic [31:0]                      s_axis_tdata_i  = '0;
  logic                             m_axis_tready_i = 1'b0;
  logic                             cfg_valid_i     = 1'b0;
  logic [fppid_pkg::CfgIdxBits-1:0] cfg_index_i     = '0;
  logic [fppid_pkg::GainBits-1:0]   cfg_data_i      = '0;
  logic                             s_axis_tready_o;
  logic                             m_axis_tvalid_o;
  logic [15:0]                      m_axis_tdata_o;
  logic                             cfg_ready_o;

  pid_drive_board board = new();

  // quiet turns off idling on both sides for the last phase; hold_req asks
  // the receiver for one long hold-off.
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  // Tracking sequences: feedback creeps toward a setpoint, which is what
  // a closed loop produces and what drives the integrator steadily.
  int trk_sp = 0;
  int trk_fb = 0;
  int settings_done = 0;

  fixed_point_pid_step #(
    .FRACTION_BITS (FracBits),
    .ACC_BITS      (AccBits)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Beat monitors. Everything the block sees is driven by nonblocking
  // assignments, so at the edge these read the values that the edge samples.
  // Registers only change while the block is drained, so the model always
  // predicts with the settings the block uses for that beat.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      board.note_sample(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_drive(m_axis_tdata_o);
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      board.write_reg(cfg_index_i, cfg_data_i);
  end

  // Offer one sample beat, sometimes after a gap, and return at the edge
  // that takes it. tvalid stays high between back-to-back beats.
  task automatic send_sample(logic signed [15:0] sp, logic signed [15:0] fb);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {fb, sp};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // The caller drops cfg_valid_i after the last write of a group.
  task automatic cfg_write(logic [fppid_pkg::CfgIdxBits-1:0] idx,
                           logic [fppid_pkg::GainBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Program all five registers; a stray write to an unused index may follow,
  // which the block has to ignore.
  task automatic apply_setting(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                               logic [15:0] floor_val, logic [15:0] ceil_val, bit stray);
    cfg_write(fppid_pkg::REG_GAIN_PROP, kp);
    cfg_write(fppid_pkg::REG_GAIN_INTEG, ki);
    cfg_write(fppid_pkg::REG_GAIN_DERIV, kd);
    cfg_write(fppid_pkg::REG_DRIVE_FLOOR, floor_val);
    cfg_write(fppid_pkg::REG_DRIVE_CEILING, ceil_val);
    if (stray)
      cfg_write(fppid_pkg::CfgIdxBits'(int'(FirstUnusedIdx) + $urandom_range(0, 2)),
                16'($urandom));
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  // Every beat yields a drive value, so an empty queue means the input and
  // result registers are empty and the block is idle.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int full_sample();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 4))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 64));
      3: return 16'($urandom_range(128, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random gains plus limits that are full, ordered, crossed, narrow,
  // equal, or taken from the extremes.
  task automatic random_setting();
    int lo, hi, t;
    case ($urandom_range(0, 5))
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: begin
        lo = full_sample();
        hi = full_sample();
        if (lo > hi) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
      2: begin
        lo = $urandom_range(1, 32767);
        hi = -int'($urandom_range(0, 32768));
      end
      3: begin
        lo = -int'($urandom_range(1, 600));
        hi = $urandom_range(1, 600);
      end
      4: begin
        lo = full_sample();
        hi = lo;
      end
      default: begin
        lo = pick_edge();
        hi = pick_edge();
      end
    endcase
    apply_setting(pick_gain(), pick_gain(), pick_gain(), 16'(lo), 16'(hi),
                  bit'($urandom_range(0, 1)));
  endtask

  // A phase is a string of short runs, each of one style. Tracking runs and
  // small values are the most common; the rest is noise and extremes.
  task automatic run_phase(int count);
    int left, run_len, style, sp, fb;
    left = count;
    while (left > 0) begin
      style   = $urandom_range(0, 5);
      run_len = $urandom_range(1, 30);
      if (run_len > left) run_len = left;
      if (style == 1 || style == 2) trk_sp = full_sample();
      repeat (run_len) begin
        case (style)
          0: begin
            sp = full_sample();
            fb = full_sample();
          end
          1, 2: begin
            trk_fb = clamp16(trk_fb + (trk_sp - trk_fb) / 8
                             + int'($urandom_range(0, 128)) - 64);
            sp = trk_sp;
            fb = trk_fb;
          end
          3: begin
            sp = pick_edge();
            fb = pick_edge();
          end
          default: begin
            sp = int'($urandom_range(0, 600)) - 300;
            fb = int'($urandom_range(0, 600)) - 300;
          end
        endcase
        send_sample(16'(sp), 16'(fb));
      end
      left -= run_len;
    end
  endtask

  // Output side. Random stalls and ready stretches, one long hold-off on
  // request, and ready held high once the run goes quiet.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: a run that stops moving beats on all three channels for too
  // long has hung.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    wait (rst_ni);
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unity proportional gain alone: full-scale errors of both signs
    // saturate at the limits, zero and unit errors pass straight through.
    apply_setting(16'd256, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b1);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'shFFFF, 16'sh0000);
    send_sample(16'sh0000, 16'shFFFF);
    wait_drained();

    // Half gain on unit errors in both directions; the maximum integral
    // gain drives the integrator into saturation, and the maximum
    // derivative gain clamps the derivative.
    apply_setting(16'd128, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'sh0001, 16'sh0000);
    send_sample(16'sh0000, 16'sh0001);
    repeat (3) send_sample(16'sh7FFF, 16'sh8000);
    repeat (3) send_sample(16'sh8000, 16'sh7FFF);
    wait_drained();

    // Crossed limits with both optional terms off: the integrator and the
    // history hold, and the drive lands on the ceiling or the floor.
    apply_setting(16'hFFFF, 16'd0, 16'd0, 16'd100, 16'hFF9C, 1'b0);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh0000);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh0001, 16'sh0002);
    wait_drained();

    // Tiny integral and derivative gains resume from the held state.
    apply_setting(16'd0, 16'd1, 16'd1, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0064, 16'shFF9C);
    send_sample(16'shFFF9, 16'sh0003);

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      if (phase == NumPhases - 1) quiet = 1'b1;
      random_setting();
      // The input keeps offering beats while the output is held off.
      if (phase == 2) hold_req = 1'b1;
      run_phase(PhaseItems);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d sample beats and %0d drive beats across %0d register settings",
             board.samples_seen, board.drives_seen, settings_done);
    $display("(%0d register writes), with random idling and one long output hold-off.",
             board.writes_seen);
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
